### rtl/core/ihex_pkg.sv
// Shared types, constants and the hex digit decoder for the hex record parser.
`timescale 1ns / 1ps

package ihex_pkg;

  // Characters with a special meaning in the record text
  localparam logic [7:0] START_CHAR = 8'h3A;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  // Offset from the low nibble of 'A'..'F' / 'a'..'f' to the digit value
  localparam logic [3:0] HEX_ALPHA_OFFSET = 4'd9;

  // Position within one record
  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_LEN   = 3'd1,
    PH_ADDR  = 3'd2,
    PH_TYPE  = 3'd3,
    PH_DATA  = 3'd4,
    PH_SUM   = 3'd5,
    PH_DONE  = 3'd6
  } phase_e;

  typedef enum logic [0:0] {
    KIND_DATA = 1'b0,
    KIND_EOR  = 1'b1
  } result_kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_BADDIGIT = 2'd2,
    ST_EARLY    = 2'd3
  } status_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  typedef struct packed {
    result_kind_e kind;
    logic [15:0]  byte_address;
    logic [7:0]   data_byte;
    logic [7:0]   record_type;
    logic [7:0]   record_length;
    status_e      record_status;
    logic         start_char_ok;
  } result_t;

  // Decode one ASCII hex digit; a non-hex character gives value zero and ok low
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    d.ok    = 1'b1;
    d.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.value = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      d.value = c[3:0] + HEX_ALPHA_OFFSET;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

### rtl/core/ihex_parser.sv
// Per-character record state update and result generation.
`timescale 1ns / 1ps

module ihex_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       char_i,
  output logic             res_valid_o,
  output ihex_pkg::result_t res_o
);

  ihex_pkg::phase_e phase_q, phase_d;
  logic [3:0]  high_q, high_d;
  logic        pending_q, pending_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  sum_q, sum_d;
  logic        start_ok_q, start_ok_d;
  logic        digit_err_q, digit_err_d;
  logic        aborted_q, aborted_d;

  ihex_pkg::hex_digit_t hex;
  logic       is_eol;
  logic [7:0] byte_val;
  logic [7:0] cnt_inc;
  logic [7:0] sum_add;
  logic       sum_bad;
  logic       err_next;
  logic       in_record;

  // Decode the character and precompute the byte-level values
  always_comb begin
    hex       = ihex_pkg::hex_decode(char_i);
    is_eol    = (char_i == ihex_pkg::CHAR_LF) || (char_i == ihex_pkg::CHAR_CR);
    byte_val  = {high_q, hex.value};
    cnt_inc   = cnt_q + 8'd1;
    sum_add   = sum_q + byte_val;
    sum_bad   = ((8'd0 - sum_q) != byte_val);
    err_next  = digit_err_q | ~hex.ok;
    in_record = (phase_q != ihex_pkg::PH_START) && (phase_q != ihex_pkg::PH_DONE);
  end

  // Next state of the record parser
  always_comb begin
    phase_d     = phase_q;
    high_d      = high_q;
    pending_d   = pending_q;
    len_d       = len_q;
    addr_d      = addr_q;
    type_d      = type_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    start_ok_d  = start_ok_q;
    digit_err_d = digit_err_q;
    aborted_d   = aborted_q;
    if (accept_i) begin
      if (is_eol) begin
        // Line end clears the record, keeps the abort
        phase_d     = ihex_pkg::PH_START;
        high_d      = 4'd0;
        pending_d   = 1'b0;
        len_d       = 8'd0;
        addr_d      = 16'd0;
        type_d      = 8'd0;
        cnt_d       = 8'd0;
        sum_d       = 8'd0;
        start_ok_d  = 1'b0;
        digit_err_d = 1'b0;
      end else if (phase_q == ihex_pkg::PH_START) begin
        start_ok_d = (char_i == ihex_pkg::START_CHAR);
        phase_d    = ihex_pkg::PH_LEN;
      end else if (phase_q != ihex_pkg::PH_DONE) begin
        digit_err_d = err_next;
        if (!pending_q) begin
          high_d    = hex.value;
          pending_d = 1'b1;
        end else begin
          pending_d = 1'b0;
          unique case (phase_q)
            ihex_pkg::PH_LEN: begin
              len_d   = byte_val;
              sum_d   = sum_add;
              cnt_d   = 8'd0;
              phase_d = ihex_pkg::PH_ADDR;
            end
            ihex_pkg::PH_ADDR: begin
              addr_d = {addr_q[7:0], byte_val};
              sum_d  = sum_add;
              if (cnt_inc >= 8'd2) begin
                cnt_d   = 8'd0;
                phase_d = ihex_pkg::PH_TYPE;
              end else begin
                cnt_d = cnt_inc;
              end
            end
            ihex_pkg::PH_TYPE: begin
              type_d  = byte_val;
              sum_d   = sum_add;
              cnt_d   = 8'd0;
              phase_d = (len_q == 8'd0) ? ihex_pkg::PH_SUM : ihex_pkg::PH_DATA;
            end
            ihex_pkg::PH_DATA: begin
              sum_d = sum_add;
              cnt_d = cnt_inc;
              if (cnt_inc == len_q) begin
                phase_d = ihex_pkg::PH_SUM;
              end
            end
            ihex_pkg::PH_SUM: begin
              if (sum_bad) begin
                aborted_d = 1'b1;
              end
              phase_d = ihex_pkg::PH_DONE;
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end
      end
    end
  end

  // Result for the accepted character, muted once aborted
  always_comb begin
    res_valid_o         = 1'b0;
    res_o.kind          = ihex_pkg::KIND_DATA;
    res_o.byte_address  = addr_q;
    res_o.data_byte     = 8'd0;
    res_o.record_type   = type_q;
    res_o.record_length = len_q;
    res_o.record_status = ihex_pkg::ST_OK;
    res_o.start_char_ok = start_ok_q;
    if (accept_i && !aborted_q && in_record) begin
      if (is_eol) begin
        res_valid_o         = 1'b1;
        res_o.kind          = ihex_pkg::KIND_EOR;
        res_o.record_status = ihex_pkg::ST_EARLY;
      end else if (pending_q && phase_q == ihex_pkg::PH_DATA) begin
        res_valid_o         = 1'b1;
        res_o.byte_address  = addr_q + {8'd0, cnt_q};
        res_o.data_byte     = byte_val;
        res_o.record_status = err_next ? ihex_pkg::ST_BADDIGIT : ihex_pkg::ST_OK;
      end else if (pending_q && phase_q == ihex_pkg::PH_SUM) begin
        res_valid_o         = 1'b1;
        res_o.kind          = ihex_pkg::KIND_EOR;
        res_o.record_status = err_next ? ihex_pkg::ST_BADDIGIT :
                              (sum_bad ? ihex_pkg::ST_MISMATCH : ihex_pkg::ST_OK);
      end
    end
  end

  // Record state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ihex_pkg::PH_START;
      high_q      <= 4'd0;
      pending_q   <= 1'b0;
      len_q       <= 8'd0;
      addr_q      <= 16'd0;
      type_q      <= 8'd0;
      cnt_q       <= 8'd0;
      sum_q       <= 8'd0;
      start_ok_q  <= 1'b0;
      digit_err_q <= 1'b0;
      aborted_q   <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      high_q      <= high_d;
      pending_q   <= pending_d;
      len_q       <= len_d;
      addr_q      <= addr_d;
      type_q      <= type_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      start_ok_q  <= start_ok_d;
      digit_err_q <= digit_err_d;
      aborted_q   <= aborted_d;
    end
  end

  // Abort is sticky until reset
  a_abort_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    aborted_q |=> aborted_q)
    else $error("abort flag cleared without reset");

  // No result leaves once aborted
  a_muted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !aborted_q)
    else $error("result produced while aborted");

  // A finished record never holds half a byte
  a_done_no_nibble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == ihex_pkg::PH_DONE) |-> !pending_q)
    else $error("pending nibble after checksum");

endmodule

### rtl/core/ihex_out_skid.sv
// Two-entry result register that keeps input flowing while a result waits.
`timescale 1ns / 1ps

module ihex_out_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ihex_pkg::result_t data_i,
  output logic              ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output ihex_pkg::result_t m_data_o
);

  logic              out_vld_q, out_vld_d;
  logic              skid_vld_q, skid_vld_d;
  ihex_pkg::result_t out_q, out_d;
  ihex_pkg::result_t skid_q, skid_d;
  logic              out_free;

  assign ready_o   = ~skid_vld_q;
  assign m_valid_o = out_vld_q;
  assign m_data_o  = out_q;
  assign out_free  = ~out_vld_q | m_ready_i;

  // Steer new results to the output register or park them in the skid entry
  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (push_i) begin
      if (out_free) begin
        out_d     = data_i;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = data_i;
        skid_vld_d = 1'b1;
      end
    end else if (out_free) begin
      out_d      = skid_q;
      out_vld_d  = skid_vld_q;
      skid_vld_d = 1'b0;
    end
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // Skid entry only fills behind a full output register
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry holds a result ahead of the output register");

  // A result pushed against a stalled output is parked
  a_skid_park: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && out_vld_q && !m_ready_i) |=> skid_vld_q)
    else $error("stalled result was not parked");

endmodule

### rtl/core/intel_hex_record_parser_top.sv
// Top level of the Intel HEX record parser.
`timescale 1ns / 1ps

// Takes one ASCII character of Intel HEX text per transaction and can accept a
// character in every cycle while the output stage has room. Each data byte of a
// record gives one result with its address, and the checksum pair (or a line that
// ends early) gives one end-of-record result with type, length, status and the
// start-character flag. Each result is captured in the output register, or in the
// skid entry while the master side stalls. The output stage holds two results, so
// s_axis_tready drops only when two results are waiting; it is a register output
// and does not depend on m_axis_tready in the same cycle. After a checksum mismatch
// all later results are suppressed until reset, while parsing continues.

module intel_hex_record_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] byte_address, [23:16] data_byte,
                                      // [31:24] record_type, [39:32] record_length,
                                      // [41:40] record_status, [42] start_char_ok,
                                      // [47:43] zero
  output logic        m_axis_tuser    // [0] result_kind
);

  logic              accept;
  logic              res_valid;
  ihex_pkg::result_t res;
  ihex_pkg::result_t out_res;

  assign accept = s_axis_tvalid & s_axis_tready;

  // Record parser
  ihex_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_i      (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register with skid entry
  ihex_out_skid u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (res_valid),
    .data_i    (res),
    .ready_o   (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (out_res)
  );

  // Pack the result fields onto the bus
  assign m_axis_tdata = {5'd0, out_res.start_char_ok, out_res.record_status,
                         out_res.record_length, out_res.record_type,
                         out_res.data_byte, out_res.byte_address};
  assign m_axis_tuser = out_res.kind;

endmodule
